// ===== hdl/stpi_pkg.sv =====
// stpi_pkg: shared constants, codes and types for the speed table interpolation block
// used by stpi_front, stpi_back and speed_table_interpolation; no dependencies
package stpi_pkg;
  localparam int NUM_CHANNELS = 16;
  localparam int NUM_POINTS   = 10;
  localparam int CH_W   = 4;
  localparam int PT_W   = 4;
  localparam int ADDR_W = $clog2(NUM_CHANNELS * NUM_POINTS);
  localparam int IDX_W  = $clog2(NUM_POINTS);

  localparam logic [1:0] REQ_COMP = 2'd0;
  localparam logic [1:0] REQ_BP   = 2'd1;
  localparam logic [1:0] REQ_OFS  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CH_W-1:0]   channel;
    logic [PT_W-1:0]   point;
    logic [15:0]       value;
    logic [15:0]       rpm;
    logic signed [15:0] raw;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;
endpackage

// ===== hdl/stpi_ram.sv =====
// stpi_ram: generic single write port, single read port ram with registered read
// no dependencies
module stpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/stpi_front.sv =====
// stpi_front: accepts input transactions, drops ignored ones, queues the rest
// depends on stpi_pkg
module stpi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  output stpi_pkg::queue_head_t head,
  input  logic                pop
);
  stpi_pkg::item_t entry [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       keep;
  logic       push;
  stpi_pkg::item_t in_item;
  logic [stpi_pkg::CH_W-1:0] ch;
  logic [stpi_pkg::PT_W-1:0] pt;

  assign ch = s_tdata[3:0];
  assign pt = s_tdata[7:4];

  always_comb begin
    in_item.kind    = s_tuser;
    in_item.channel = ch;
    in_item.point   = pt;
    in_item.value   = s_tdata[23:8];
    in_item.rpm     = s_tdata[40:25];
    in_item.raw     = $signed(s_tdata[56:41]);
    case (s_tuser)
      stpi_pkg::REQ_COMP: keep = 32'(ch) < stpi_pkg::NUM_CHANNELS;
      stpi_pkg::REQ_BP:   keep = 32'(pt) < stpi_pkg::NUM_POINTS;
      stpi_pkg::REQ_OFS:  keep = (32'(ch) < stpi_pkg::NUM_CHANNELS) &&
                                 (32'(pt) < stpi_pkg::NUM_POINTS);
      default:            keep = 1'b0;
    endcase
  end

  assign s_tready   = count != 2'd2;
  assign push       = s_tvalid && s_tready && keep;
  assign head.valid = count != 2'd0;
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");
endmodule

// ===== hdl/stpi_back.sv =====
// stpi_back: executes queued items: table writes, segment search, interpolation,
// serial rounding division and saturation; depends on stpi_pkg and stpi_ram
module stpi_back (
  input  logic                  clk,
  input  logic                  rst,
  input  stpi_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,
  output logic [1:0]            m_tuser
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_RDC  = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam int AW = stpi_pkg::ADDR_W;
  localparam int IW = stpi_pkg::IDX_W;

  logic [3:0] state;
  logic [15:0] bp [stpi_pkg::NUM_POINTS];
  logic [IW-1:0] j;
  logic [IW-1:0] k;
  logic [stpi_pkg::CH_W-1:0] ch;
  logic [15:0] rpm;
  logic signed [15:0] raw;
  logic [15:0] b0, b1;
  logic signed [15:0] c0, c1;
  logic signed [32:0] p1;
  logic signed [33:0] p2;
  logic signed [16:0] den, drpm, dc;
  logic signed [34:0] num;
  logic signed [16:0] dpos;
  logic signed [36:0] nn;
  logic [17:0] dvsr;
  logic [17:0] rem;
  logic [36:0] quo;
  logic [18:0] trial;
  logic [5:0] cnt;
  logic neg, zflag;
  logic signed [37:0] q;
  logic signed [38:0] sum;
  logic [31:0] res_value;
  logic [1:0] res_status;
  logic ram_we;
  logic [AW-1:0] waddr, raddr, base;
  logic [15:0] rdata;

  stpi_ram #(.WIDTH(16), .DEPTH(stpi_pkg::NUM_CHANNELS * stpi_pkg::NUM_POINTS)) u_ofs (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(head.item.value),
    .raddr(raddr), .rdata(rdata)
  );

  assign pop    = (state == S_IDLE) && head.valid;
  assign ram_we = pop && (head.item.kind == stpi_pkg::REQ_OFS);
  assign waddr  = AW'(head.item.channel) * AW'(stpi_pkg::NUM_POINTS) + AW'(head.item.point);
  assign base   = AW'(ch) * AW'(stpi_pkg::NUM_POINTS);
  assign raddr  = (state == S_RDA) ? base + AW'(k) - AW'(1) : base + AW'(k);

  assign den   = $signed({1'b0, b1}) - $signed({1'b0, b0});
  assign drpm  = $signed({1'b0, rpm}) - $signed({1'b0, b0});
  assign dc    = 17'(c1) - 17'(c0);
  assign trial = {rem, quo[36]};
  assign q     = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum   = 39'(raw) + 39'(q);

  always_comb begin
    if (den == 17'sd0) begin
      num  = 35'(c0);
      dpos = 17'sd1;
    end else if (den < 17'sd0) begin
      num  = -(35'(p1) + 35'(p2));
      dpos = -den;
    end else begin
      num  = 35'(p1) + 35'(p2);
      dpos = den;
    end
    nn = (37'(num) <<< 1) + 37'(dpos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.item.kind == stpi_pkg::REQ_BP) begin
              bp[IW'(head.item.point)] <= head.item.value;
            end
            if (head.item.kind == stpi_pkg::REQ_COMP) begin
              ch    <= head.item.channel;
              rpm   <= head.item.rpm;
              raw   <= head.item.raw;
              j     <= IW'(1);
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (rpm <= bp[j] || 32'(j) == stpi_pkg::NUM_POINTS - 1) begin
            k     <= j;
            state <= S_RDA;
          end else begin
            j <= j + IW'(1);
          end
        end
        S_RDA: begin
          b0    <= bp[k - IW'(1)];
          state <= S_RDB;
        end
        S_RDB: begin
          b1    <= bp[k];
          c0    <= $signed(rdata);
          state <= S_RDC;
        end
        S_RDC: begin
          c1    <= $signed(rdata);
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1    <= c0 * den;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= dc * drpm;
          state <= S_PREP;
        end
        S_PREP: begin
          zflag <= den == 17'sd0;
          neg   <= nn < 37'sd0;
          quo   <= (nn < 37'sd0) ? 37'(-nn) : 37'(nn);
          dvsr  <= {dpos[16:0], 1'b0};
          rem   <= 18'd0;
          cnt   <= 6'd37;
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, dvsr}) begin
            rem <= 18'(trial - {1'b0, dvsr});
            quo <= {quo[35:0], 1'b1};
          end else begin
            rem <= trial[17:0];
            quo <= {quo[35:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (sum > 39'sd2147483647) begin
            res_value  <= 32'h7FFF_FFFF;
            res_status <= stpi_pkg::ST_SAT;
          end else if (sum < -39'sd2147483648) begin
            res_value  <= 32'h8000_0000;
            res_status <= stpi_pkg::ST_SAT;
          end else begin
            res_value  <= sum[31:0];
            res_status <= zflag ? stpi_pkg::ST_ZERO : stpi_pkg::ST_OK;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, ch, res_value};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> state == S_IDLE)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> 32'(j) < stpi_pkg::NUM_POINTS)
    else $error("search index out of table");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> rem < dvsr)
    else $error("division remainder not reduced");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("bad status code");
endmodule

// ===== hdl/speed_table_interpolation.sv =====
// speed_table_interpolation: top level of the speed compensation block
// depends on stpi_pkg, stpi_front, stpi_back, stpi_ram
//
// input stream (s_*): write breakpoint, write channel offset point or
// compensate sample, selected by s_tuser; writes give no output transaction
// output stream (m_*): one transaction per compensate item, in order
// a compensate item passes through the queue, a breakpoint search (one
// compare a cycle), table reads, two multiplies, a 37-bit restoring
// divider (one quotient bit a cycle), saturation and output; the back
// end takes no new item from the queue until the current compensate
// item has been put into the output register
// a write item is completed in the back end in the cycle it is popped
// a two-entry queue parts input from execution, so input keeps flowing
// while a result waits in the output register
// when m_tready is low the finished result is held and execution stops
// after its next result is ready; input stalls once the queue fills
// reset empties the queue and output; table contents are kept and an
// entry must be written before it is read
module speed_table_interpolation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // channel, point, write_value, rpm, raw_value
  input  logic [1:0]  s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // comp_value, out_channel
  output logic [1:0]  m_tuser   // status
);
  stpi_pkg::queue_head_t head;
  logic pop;

  stpi_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .head(head), .pop(pop)
  );

  stpi_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
endmodule

// ===== dv/tb.sv =====
// tb: self-checking testbench for speed_table_interpolation (piecewise linear speed compensation)
// depends on stpi_pkg and the rtl under hdl; drives table writes and compensate transactions,
// predicts each result in a local model and compares it on the output stream
`timescale 1ns / 100ps

module tb;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         ch;
    logic [3:0]         pt;
    logic [16:0]        wv;
    logic [15:0]        rpm;
    logic signed [15:0] raw;
    bit                 drain;
  } req_t;

  typedef struct {
    logic [31:0] comp;
    logic [3:0]  ch;
    logic [1:0]  st;
  } comp_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  speed_table_interpolation dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  req_t               pending_reqs[$];
  comp_res_t          expected_comps[$];
  req_t               cur_req;
  logic [15:0]        bp_tbl[stpi_pkg::NUM_POINTS];
  logic signed [15:0] ofs_tbl[stpi_pkg::NUM_CHANNELS][stpi_pkg::NUM_POINTS];
  bit                 in_flight = 0;
  int                 send_gap = 0;
  int                 stall_cnt = 0;
  bit                 calm_mode = 0;
  int                 n_mismatch = 0;
  int                 n_results = 0;
  int                 n_comp_sent = 0;
  int                 n_sat = 0;
  int                 n_zero = 0;
  int                 n_writes = 0;

  function automatic comp_res_t compensate(logic [3:0] ch, logic [15:0] rpm,
                                           logic signed [15:0] raw);
    comp_res_t r;
    int k;
    longint b0, b1, c0, c1, num, den, q, sum;
    r.st = stpi_pkg::ST_OK;
    k = stpi_pkg::NUM_POINTS - 1;
    for (int j = stpi_pkg::NUM_POINTS - 2; j >= 1; j--)
      if (rpm <= bp_tbl[j]) k = j;
    b0 = bp_tbl[k-1];
    b1 = bp_tbl[k];
    c0 = ofs_tbl[ch][k-1];
    c1 = ofs_tbl[ch][k];
    den = b1 - b0;
    if (den == 0) begin
      num = c0;
      den = 1;
      r.st = stpi_pkg::ST_ZERO;
    end else begin
      num = c0 * den + (c1 - c0) * (longint'(rpm) - b0);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
    end
    q = (2 * num + den) / (2 * den);
    sum = longint'(raw) + q;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      r.st = stpi_pkg::ST_SAT;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      r.st = stpi_pkg::ST_SAT;
    end
    r.comp = sum[31:0];
    r.ch = ch;
    return r;
  endfunction

  function automatic void push_bp(int pt, logic [16:0] v);
    req_t r;
    r = '{stpi_pkg::REQ_BP, 4'($urandom), 4'(pt), v, 16'($urandom), 16'($urandom), 0};
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_ofs(int ch, int pt, logic [16:0] v);
    req_t r;
    r = '{stpi_pkg::REQ_OFS, 4'(ch), 4'(pt), v, 16'($urandom), 16'($urandom), 0};
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_comp(int ch, logic [15:0] rpm, logic signed [15:0] raw);
    req_t r;
    r = '{stpi_pkg::REQ_COMP, 4'(ch), 4'($urandom), 17'($urandom), rpm, raw, 0};
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_drain();
    req_t r;
    r = '{REQ_NONE, 4'd0, 4'd0, 17'd0, 16'd0, 16'sd0, 1};
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [16:0] rand_ofs();
    return 17'(int'($urandom_range(0, 65535)) - 32768);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm_mode || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // new breakpoint table: sorted, sorted with repeats, or unordered
  function automatic void load_bp_table();
    int vals[$];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < stpi_pkg::NUM_POINTS; i++)
      vals.push_back(mode < 2 ? $urandom_range(0, 30) : $urandom_range(0, 65535));
    if (mode < 8) vals.sort();
    for (int i = 0; i < stpi_pkg::NUM_POINTS; i++) push_bp(i, 17'(vals[i]));
  endfunction

  // sampling and checking at the rising edge
  always @(posedge clk) begin
    comp_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (expected_comps.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected output transaction: comp %0d ch %0d status %0d",
                   $signed(m_tdata[31:0]), m_tdata[35:32], m_tuser);
      end else begin
        e = expected_comps.pop_front();
        if (e.comp !== m_tdata[31:0] || e.ch !== m_tdata[35:32] || e.st !== m_tuser) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch: expected comp %0d ch %0d status %0d, ",
                      "got comp %0d ch %0d status %0d"},
                     $signed(e.comp), e.ch, e.st, $signed(m_tdata[31:0]), m_tdata[35:32],
                     m_tuser);
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      in_flight = 0;
      case (cur_req.kind)
        stpi_pkg::REQ_BP: begin
          n_writes++;
          if (cur_req.pt < stpi_pkg::NUM_POINTS) bp_tbl[cur_req.pt] = cur_req.wv[15:0];
        end
        stpi_pkg::REQ_OFS: begin
          n_writes++;
          if (cur_req.pt < stpi_pkg::NUM_POINTS && cur_req.ch < stpi_pkg::NUM_CHANNELS)
            ofs_tbl[cur_req.ch][cur_req.pt] = cur_req.wv[15:0];
        end
        stpi_pkg::REQ_COMP: begin
          if (cur_req.ch < stpi_pkg::NUM_CHANNELS) begin
            e = compensate(cur_req.ch, cur_req.rpm, cur_req.raw);
            if (e.st == stpi_pkg::ST_SAT) n_sat++;
            if (e.st == stpi_pkg::ST_ZERO) n_zero++;
            expected_comps.push_back(e);
          end
        end
        default: ;
      endcase
    end
  end

  // driver and output backpressure at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_flight) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_comps.size() > 0)) begin
          if (pending_reqs[0].drain) begin
            void'(pending_reqs.pop_front());
            s_tvalid <= 0;
          end else begin
            cur_req = pending_reqs.pop_front();
            s_tdata <= {7'd0, cur_req.raw, cur_req.rpm, cur_req.wv, cur_req.pt, cur_req.ch};
            s_tuser <= cur_req.kind;
            s_tvalid <= 1;
            in_flight = 1;
            if (cur_req.kind == stpi_pkg::REQ_COMP) begin
              n_comp_sent++;
              if (n_comp_sent % 300 == 0) calm_mode = ~calm_mode;
            end
            send_gap = pick_gap();
          end
        end else begin
          s_tvalid <= 0;
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        stall_cnt = pick_gap();
      end
    end
  end

  initial begin
    int ncomp;
    int base;
    // whole table loaded first so no unwritten entry is ever read
    for (int i = 0; i < stpi_pkg::NUM_POINTS; i++) push_bp(i, 17'(i * 1000));
    for (int c = 0; c < stpi_pkg::NUM_CHANNELS; c++)
      for (int p = 0; p < stpi_pkg::NUM_POINTS; p++) push_ofs(c, p, rand_ofs());

    // directed: field extremes, ignored items, zero width, descending, saturation
    push_ofs(0, 0, 17'h18000);
    push_ofs(0, 1, 17'h07FFF);
    push_comp(0, 16'd0, -16'sd32768);
    push_comp(15, 16'hFFFF, 16'sd32767);
    push_comp(0, 16'd500, 16'sd0);
    pending_reqs.push_back('{REQ_NONE, 4'hF, 4'hF, 17'h1FFFF, 16'hFFFF, -16'sd1, 0});
    push_bp(12, 17'h0FFFF);
    push_ofs(3, 15, 17'h1FFFF);
    push_bp(3, 17'd2000);
    push_comp(5, 16'd2000, 16'sd100);
    push_comp(5, 16'd2500, -16'sd100);
    push_bp(9, 17'd100);
    push_comp(7, 16'd9000, 16'sd7);
    push_comp(7, 16'hFFFF, 16'sd7);
    push_bp(8, 17'd100);
    push_bp(9, 17'd101);
    push_ofs(2, 8, 17'h18000);
    push_ofs(2, 9, 17'h07FFF);
    push_comp(2, 16'hFFFF, 16'sd32767);
    push_ofs(2, 8, 17'h07FFF);
    push_ofs(2, 9, 17'h18000);
    push_comp(2, 16'hFFFF, -16'sd32768);
    push_comp(2, 16'd100, 16'sd1);
    push_drain();

    // random: mostly compensate transactions, with table rewrites between bursts
    ncomp = 0;
    while (ncomp < 1000) begin
      if ($urandom_range(0, 3) == 0) load_bp_table();
      repeat ($urandom_range(0, 12))
        push_ofs($urandom_range(0, 15), $urandom_range(0, 9), rand_ofs());
      if ($urandom_range(0, 9) == 0)
        push_ofs($urandom_range(0, 15), $urandom_range(10, 15), 17'($urandom));
      repeat ($urandom_range(20, 60)) begin
        case ($urandom_range(0, 9))
          0: begin
            base = bp_tbl[$urandom_range(0, 9)];
            push_comp($urandom_range(0, 15), 16'(base + int'($urandom_range(0, 4)) - 2),
                      16'($urandom));
          end
          1: pending_reqs.push_back('{REQ_NONE, 4'($urandom), 4'($urandom), 17'($urandom),
                                      16'($urandom), 16'($urandom), 0});
          default: push_comp($urandom_range(0, 15), 16'($urandom), 16'($urandom));
        endcase
        ncomp++;
      end
      if ($urandom_range(0, 7) == 0) push_drain();
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 0;
    wait (pending_reqs.size() == 0 && !in_flight);
    wait (expected_comps.size() == 0);
    repeat (200) @(posedge clk);
    $display("tb: %0d compensate transactions sent, %0d results checked, %0d table writes",
             n_comp_sent, n_results, n_writes);
    $display("tb: %0d saturated, %0d zero-width segment results, %0d mismatches",
             n_sat, n_zero, n_mismatch);
    if (n_mismatch == 0 && expected_comps.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout: %0d results still expected", expected_comps.size());
    $display("tb: errors");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/stpi_pkg.sv
hdl/stpi_ram.sv
hdl/stpi_front.sv
hdl/stpi_back.sv
hdl/speed_table_interpolation.sv
dv/tb.sv
